[rtl/lpf_pkg.sv]
// Shared types, codes and helpers for the IPv6 longest-prefix forwarding block.
// Used by lpf_cell and ipv6_longest_prefix_forward; depends on nothing else.
package lpf_pkg;

  localparam int DefaultTableDepth = 64;
  localparam int AddrW = 128;
  localparam int LenW = 8;
  localparam int HopLimitW = 8;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 64;
  localparam logic [LenW-1:0] MaxPrefixLen = 8'd128;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_FWD = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_LOCAL_HI = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_LOCAL_LO = 1'b1;

  typedef enum logic [2:0] {
    V_FORWARD = 3'd0,
    V_LOCAL   = 3'd1,
    V_HOPLIM  = 3'd2,
    V_NOROUTE = 3'd3,
    V_ADDED   = 3'd4,
    V_FULL    = 3'd5
  } verdict_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] prefix;
    logic [AddrW-1:0] mask;
    logic [LenW-1:0]  len;
    logic [AddrW-1:0] hop;
  } route_wr_t;

  typedef struct packed {
    logic                 valid;
    logic [AddrW-1:0]     addr;
    logic [HopLimitW-1:0] hop_limit;
    logic [LenW-1:0]      best_len;
    logic [AddrW-1:0]     best_hop;
  } query_t;

  function automatic logic [LenW-1:0] sat_len(input logic [LenW-1:0] len);
    sat_len = (len > MaxPrefixLen) ? MaxPrefixLen : len;
  endfunction

  function automatic logic [AddrW-1:0] prefix_mask(input logic [LenW-1:0] len);
    logic [AddrW-1:0] m;
    m = '0;
    for (int i = 0; i < AddrW; i++) begin
      m[AddrW-1-i] = (LenW'(i) < len);
    end
    prefix_mask = m;
  endfunction

endpackage

[rtl/lpf_cell.sv]
// One route cell of the lookup chain: stores one route and refines the best match
// of the query passing through it. Depends on lpf_pkg.
module lpf_cell #(
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CNT_W-1:0]   count,
  input  lpf_pkg::route_wr_t wr,
  input  lpf_pkg::query_t    q_in,
  output lpf_pkg::query_t    q_out
);
  import lpf_pkg::*;

  logic [AddrW-1:0] prefix;
  logic [AddrW-1:0] mask;
  logic [LenW-1:0]  len;
  logic [AddrW-1:0] hop;
  logic             take;

  always_ff @(posedge clk) begin
    if (wr.en && count == CNT_W'(INDEX)) begin
      prefix <= wr.prefix;
      mask   <= wr.mask;
      len    <= wr.len;
      hop    <= wr.hop;
    end
  end

  always_comb begin
    take = (CNT_W'(INDEX) < count) && (((q_in.addr ^ prefix) & mask) == '0) &&
           (len > q_in.best_len);
  end

  always_ff @(posedge clk) begin
    q_out.addr      <= q_in.addr;
    q_out.hop_limit <= q_in.hop_limit;
    q_out.best_len  <= take ? len : q_in.best_len;
    q_out.best_hop  <= take ? hop : q_in.best_hop;
    if (rst) begin
      q_out.valid <= 1'b0;
    end else begin
      q_out.valid <= q_in.valid;
    end
  end

endmodule

[rtl/ipv6_longest_prefix_forward.sv]
// IPv6 route table with longest-prefix forwarding decisions. Routes live in a row of
// TABLE_DEPTH cells, one route per cell; a lookup walks the row one cell per cycle. A
// forward transaction that needs a route search gives its result when the query leaves the
// last cell and is registered at the output; add, hop limit and local delivery transactions
// give theirs in the cycle after acceptance. One transaction is handled at a time: the
// input is stalled during a search and while an earlier result waits on a stalled output.
// There is no clearing pass. Top level; depends on lpf_pkg and lpf_cell.
module ipv6_longest_prefix_forward #(
  parameter int TABLE_DEPTH = lpf_pkg::DefaultTableDepth
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [lpf_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [lpf_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [63:0]                      addr_hi,
  input  logic [63:0]                      addr_lo,
  input  logic [7:0]                       prefix_len,
  input  logic [63:0]                      hop_hi,
  input  logic [63:0]                      hop_lo,
  input  logic [7:0]                       hop_limit,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       verdict,
  output logic [63:0]                      next_hi,
  output logic [63:0]                      next_lo,
  output logic [7:0]                       new_hop_limit
);
  import lpf_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [63:0]      local_hi;
  logic [63:0]      local_lo;
  logic [CNT_W-1:0] count;
  logic             scanning;
  logic             in_acc;
  logic             full;
  logic             inject;
  route_wr_t        wr;
  query_t           chain [0:TABLE_DEPTH];
  query_t           tail;

  verdict_t         res_verdict;
  logic [AddrW-1:0] res_hop;
  logic [7:0]       res_hl;
  logic             res_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_hi <= '0;
      local_lo <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LOCAL_HI: local_hi <= cfg_data;
        REG_LOCAL_LO: local_lo <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = scanning || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count == CNT_W'(TABLE_DEPTH));
  assign inject   = in_acc && cmd == CMD_FWD && hop_limit != '0 &&
                    !(addr_hi == local_hi && addr_lo == local_lo);

  always_comb begin
    wr.en     = in_acc && cmd == CMD_ADD && !full;
    wr.prefix = {addr_hi, addr_lo};
    wr.len    = sat_len(prefix_len);
    wr.mask   = prefix_mask(sat_len(prefix_len));
    wr.hop    = {hop_hi, hop_lo};
  end

  always_comb begin
    chain[0].valid     = inject;
    chain[0].addr      = {addr_hi, addr_lo};
    chain[0].hop_limit = hop_limit;
    chain[0].best_len  = '0;
    chain[0].best_hop  = '0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    lpf_cell #(
      .CNT_W(CNT_W),
      .INDEX(i)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .count(count),
      .wr   (wr),
      .q_in (chain[i]),
      .q_out(chain[i+1])
    );
  end

  assign tail = chain[TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      scanning <= 1'b0;
    end else begin
      if (wr.en) begin
        count <= count + 1'b1;
      end
      if (inject) begin
        scanning <= 1'b1;
      end else if (tail.valid) begin
        scanning <= 1'b0;
      end
    end
  end

  always_comb begin
    res_load    = 1'b0;
    res_verdict = V_ADDED;
    res_hop     = '0;
    res_hl      = hop_limit;
    if (tail.valid) begin
      res_load = 1'b1;
      res_hl   = tail.hop_limit;
      if (tail.best_len == '0) begin
        res_verdict = V_NOROUTE;
      end else begin
        res_verdict = V_FORWARD;
        res_hop     = tail.best_hop;
        res_hl      = tail.hop_limit - 8'd1;
      end
    end else if (in_acc && !inject) begin
      res_load = 1'b1;
      if (cmd == CMD_ADD) begin
        res_verdict = full ? V_FULL : V_ADDED;
      end else if (hop_limit == '0) begin
        res_verdict = V_HOPLIM;
      end else begin
        res_verdict = V_LOCAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      verdict       <= res_verdict;
      next_hi       <= res_hop[AddrW-1:64];
      next_lo       <= res_hop[63:0];
      new_hop_limit <= res_hl;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("route count beyond table depth");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> scanning)
    else $error("lookup result without a search in progress");

  a_tail_out_free: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> !out_valid)
    else $error("lookup result would overwrite a pending result");
`endif

endmodule
